>>> hdl/hrle_pkg.sv
package hrle_pkg;

	// Input operation codes.
	localparam logic [1:0] OP_RX   = 2'd0;
	localparam logic [1:0] OP_GET  = 2'd1;
	localparam logic [1:0] OP_SET  = 2'd2;
	localparam logic [1:0] OP_TICK = 2'd3;

	// Result kinds.
	localparam logic [1:0] KIND_TX      = 2'd0;
	localparam logic [1:0] KIND_VALUE   = 2'd1;
	localparam logic [1:0] KIND_NACK    = 2'd2;
	localparam logic [1:0] KIND_TIMEOUT = 2'd3;

	// Command digits of the line protocol.
	localparam logic [3:0] CMD_GET  = 4'h7;
	localparam logic [3:0] CMD_SET  = 4'h8;
	localparam logic [3:0] CMD_NACK = 4'hA;

	// Framing characters and checksum target.
	localparam logic [7:0] CH_COLON   = 8'h3A;
	localparam logic [7:0] CH_NL      = 8'h0A;
	localparam logic [7:0] CHECK_SUM  = 8'h55;

	// Configuration register indexes (word address bit 2).
	localparam logic REG_TARGET  = 1'b0;
	localparam logic REG_TIMEOUT = 1'b1;

	// Configuration reset values.
	localparam logic [15:0] TARGET_RESET  = 16'd8213;
	localparam logic [15:0] TIMEOUT_RESET = 16'd5000;

	// Frame length limit default.
	localparam int MAX_FRAME_CHARS_DEF = 100;

	// Position of the newline in an outgoing get or set frame.
	localparam logic [3:0] GET_LAST_POS = 4'd10;
	localparam logic [3:0] SET_LAST_POS = 4'd14;

	// Job queue depth and pointer width.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// Work handed from the front end to the back end.
	typedef enum logic [2:0] {
		JOB_GET,
		JOB_SET,
		JOB_VALUE,
		JOB_NACK,
		JOB_TIMEOUT
	} job_kind_t;

	typedef struct packed {
		job_kind_t   kind;
		logic [15:0] reg_id;
		logic [15:0] value;
	} job_t;

	// Queue status seen by both ends.
	typedef struct packed {
		logic full;
		logic nonempty;
	} queue_stat_t;

	// Back end sequencer states.
	typedef enum logic {
		BK_IDLE,
		BK_FRAME
	} back_state_t;

	// Uppercase hex digit for a nibble.
	function automatic logic [7:0] hex_char(input logic [3:0] v);
		logic [7:0] r;
		if (v < 4'd10) begin
			r = 8'h30 + {4'h0, v};
		end else begin
			r = 8'h41 + {4'h0, v} - 8'd10;
		end
		return r;
	endfunction

	// Hex digit decode: bit 4 flags a valid digit, bits 3:0 hold its value.
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end
		return r;
	endfunction

endpackage

>>> hdl/hrle_if.sv
// Request channel into the endpoint.
interface hrle_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [7:0]  rx_char;
	logic [15:0] set_value;

	modport source (output valid, opcode, rx_char, set_value, input ready);
	modport sink (input valid, opcode, rx_char, set_value, output ready);
endinterface

// Result channel out of the endpoint.
interface hrle_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  tx_char;
	logic [15:0] reply_value;
	logic        last;

	modport source (output valid, kind, tx_char, reply_value, last, input ready);
	modport sink (input valid, kind, tx_char, reply_value, last, output ready);
endinterface

>>> hdl/hrle_queue.sv
module hrle_queue
	import hrle_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  job_t        push_job,
	input  logic        pop,
	output job_t        head_job,
	output queue_stat_t stat
);

	localparam logic [QPTR_W:0] FULL_COUNT = (QPTR_W + 1)'(QUEUE_DEPTH);

	job_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign stat.full     = (count_q == FULL_COUNT);
	assign stat.nonempty = (count_q != '0);
	assign head_job      = mem_q[rd_ptr_q];

	// Storage is written at the tail only.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> hdl/hrle_front.sv
module hrle_front
	import hrle_pkg::*;
#(
	parameter int MAX_FRAME_CHARS = MAX_FRAME_CHARS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	hrle_in_if.sink     in_ch,
	input  logic [15:0] target_register,
	input  logic [15:0] timeout_ticks,
	input  queue_stat_t qstat,
	output logic        push,
	output job_t        push_job
);

	localparam logic [6:0] MAX_CHARS = 7'(MAX_FRAME_CHARS);

	logic        in_frame_q, in_frame_d;
	logic [6:0]  frame_chars_q, frame_chars_d;
	logic        type_seen_q, type_seen_d;
	logic        nibble_phase_q, nibble_phase_d;
	logic [3:0]  held_nibble_q, held_nibble_d;
	logic [2:0]  byte_index_q, byte_index_d;
	logic [3:0]  reply_type_q, reply_type_d;
	logic [15:0] reply_register_q, reply_register_d;
	logic [15:0] reply_data_q, reply_data_d;
	logic        bad_digit_q, bad_digit_d;
	logic        waiting_q, waiting_d;
	logic [15:0] elapsed_q, elapsed_d;

	logic        accept;
	logic [4:0]  digit;
	logic [7:0]  rx_byte;

	assign in_ch.ready = !qstat.full;
	assign accept      = in_ch.valid && in_ch.ready;
	assign digit       = hex_decode(in_ch.rx_char);
	assign rx_byte     = {held_nibble_q, digit[3:0]};

	// Per-request decode, receive framing and wait tracking.
	always_comb begin
		in_frame_d       = in_frame_q;
		frame_chars_d    = frame_chars_q;
		type_seen_d      = type_seen_q;
		nibble_phase_d   = nibble_phase_q;
		held_nibble_d    = held_nibble_q;
		byte_index_d     = byte_index_q;
		reply_type_d     = reply_type_q;
		reply_register_d = reply_register_q;
		reply_data_d     = reply_data_q;
		bad_digit_d      = bad_digit_q;
		waiting_d        = waiting_q;
		elapsed_d        = elapsed_q;
		push             = 1'b0;
		push_job.kind    = JOB_VALUE;
		push_job.reg_id  = target_register;
		push_job.value   = 16'd0;

		if (accept) begin
			case (in_ch.opcode)
				OP_RX: begin
					if (in_ch.rx_char == CH_COLON) begin
						// A colon always opens a fresh frame.
						in_frame_d       = 1'b1;
						frame_chars_d    = 7'd1;
						type_seen_d      = 1'b0;
						nibble_phase_d   = 1'b0;
						held_nibble_d    = 4'd0;
						byte_index_d     = 3'd0;
						reply_type_d     = 4'd0;
						reply_register_d = 16'd0;
						reply_data_d     = 16'd0;
						bad_digit_d      = 1'b0;
					end else if (in_frame_q) begin
						if (in_ch.rx_char == CH_NL) begin
							// Frame end: report a matching reply or a NACK.
							in_frame_d    = 1'b0;
							frame_chars_d = 7'd0;
							if (!bad_digit_q && type_seen_q && byte_index_q != 3'd0) begin
								if (reply_type_q == CMD_GET || reply_type_q == CMD_SET) begin
									if (byte_index_q >= 3'd6 &&
									    reply_register_q == target_register) begin
										waiting_d      = 1'b0;
										push           = 1'b1;
										push_job.kind  = JOB_VALUE;
										push_job.value = reply_data_q;
									end
								end else if (reply_type_q == CMD_NACK) begin
									waiting_d     = 1'b0;
									push          = 1'b1;
									push_job.kind = JOB_NACK;
								end
							end
						end else if (frame_chars_q >= MAX_CHARS) begin
							// Overlong frame is dropped.
							in_frame_d    = 1'b0;
							frame_chars_d = 7'd0;
						end else begin
							frame_chars_d = frame_chars_q + 7'd1;
							if (!digit[4]) begin
								bad_digit_d = 1'b1;
							end else if (!type_seen_q) begin
								reply_type_d = digit[3:0];
								type_seen_d  = 1'b1;
							end else if (!nibble_phase_q) begin
								held_nibble_d  = digit[3:0];
								nibble_phase_d = 1'b1;
							end else begin
								// Second nibble completes a byte.
								nibble_phase_d = 1'b0;
								case (byte_index_q)
									3'd0: reply_register_d[7:0]  = rx_byte;
									3'd1: reply_register_d[15:8] = rx_byte;
									3'd3: reply_data_d[7:0]      = rx_byte;
									3'd4: reply_data_d[15:8]     = rx_byte;
									default: ;
								endcase
								if (byte_index_q != 3'd7) begin
									byte_index_d = byte_index_q + 3'd1;
								end
							end
						end
					end
				end
				OP_GET, OP_SET: begin
					// A request restarts the wait and queues a frame.
					waiting_d      = 1'b1;
					elapsed_d      = 16'd0;
					push           = 1'b1;
					push_job.kind  = (in_ch.opcode == OP_SET) ? JOB_SET : JOB_GET;
					push_job.value = in_ch.set_value;
				end
				OP_TICK: begin
					if (waiting_q) begin
						if (elapsed_q >= timeout_ticks) begin
							waiting_d     = 1'b0;
							push          = 1'b1;
							push_job.kind = JOB_TIMEOUT;
						end else begin
							elapsed_d = elapsed_q + 16'd1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q     <= 1'b0;
			frame_chars_q  <= 7'd0;
			type_seen_q    <= 1'b0;
			nibble_phase_q <= 1'b0;
			byte_index_q   <= 3'd0;
			reply_type_q   <= 4'd0;
			bad_digit_q    <= 1'b0;
			waiting_q      <= 1'b0;
			elapsed_q      <= 16'd0;
		end else begin
			in_frame_q     <= in_frame_d;
			frame_chars_q  <= frame_chars_d;
			type_seen_q    <= type_seen_d;
			nibble_phase_q <= nibble_phase_d;
			byte_index_q   <= byte_index_d;
			reply_type_q   <= reply_type_d;
			bad_digit_q    <= bad_digit_d;
			waiting_q      <= waiting_d;
			elapsed_q      <= elapsed_d;
		end
	end

	// Decoded payload of the frame in progress.
	always_ff @(posedge clk) begin
		held_nibble_q    <= held_nibble_d;
		reply_register_q <= reply_register_d;
		reply_data_q     <= reply_data_d;
	end

endmodule

>>> hdl/hrle_back.sv
module hrle_back
	import hrle_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  queue_stat_t qstat,
	input  job_t        head_job,
	output logic        pop,
	hrle_out_if.source  out_ch
);

	back_state_t state_q, state_d;
	logic [3:0]  pos_q, pos_d;
	logic        is_set_q;
	logic [3:0]  cmd_q;
	logic [7:0]  bytes_q [6];

	logic        out_valid_q, out_valid_d;
	logic [1:0]  kind_q, kind_d;
	logic [7:0]  char_q, char_d;
	logic [15:0] value_q, value_d;
	logic        last_q, last_d;

	logic        slot_free;
	logic        load;
	logic [3:0]  last_pos;
	logic [3:0]  offs;
	logic [7:0]  cur_byte;
	logic [7:0]  frame_char;
	logic        job_set;
	logic [3:0]  job_cmd;
	logic [7:0]  chk;

	assign out_ch.valid       = out_valid_q;
	assign out_ch.kind        = kind_q;
	assign out_ch.tx_char     = char_q;
	assign out_ch.reply_value = value_q;
	assign out_ch.last        = last_q;

	assign slot_free = !out_valid_q || out_ch.ready;
	assign last_pos  = is_set_q ? SET_LAST_POS : GET_LAST_POS;

	// Character at the current frame position.
	assign offs     = pos_q - 4'd2;
	assign cur_byte = (offs[3:1] < 3'd6) ? bytes_q[offs[3:1]] : 8'd0;
	always_comb begin
		if (pos_q == last_pos) begin
			frame_char = CH_NL;
		end else if (pos_q == 4'd1) begin
			frame_char = hex_char(cmd_q);
		end else begin
			frame_char = hex_char(offs[0] ? cur_byte[3:0] : cur_byte[7:4]);
		end
	end

	// Checksum of a new command frame.
	assign job_set = (head_job.kind == JOB_SET);
	assign job_cmd = job_set ? CMD_SET : CMD_GET;
	assign chk = CHECK_SUM - ({4'h0, job_cmd} + head_job.reg_id[7:0] + head_job.reg_id[15:8]
	             + (job_set ? (head_job.value[7:0] + head_job.value[15:8]) : 8'd0));

	// Sequencer: next state and output register contents.
	always_comb begin
		state_d     = state_q;
		pos_d       = pos_q;
		pop         = 1'b0;
		load        = 1'b0;
		out_valid_d = out_valid_q && !out_ch.ready;
		kind_d      = kind_q;
		char_d      = char_q;
		value_d     = value_q;
		last_d      = last_q;

		case (state_q)
			BK_IDLE: begin
				if (slot_free && qstat.nonempty) begin
					pop         = 1'b1;
					out_valid_d = 1'b1;
					char_d      = 8'd0;
					value_d     = 16'd0;
					last_d      = 1'b1;
					case (head_job.kind)
						JOB_GET, JOB_SET: begin
							load    = 1'b1;
							kind_d  = KIND_TX;
							char_d  = CH_COLON;
							last_d  = 1'b0;
							pos_d   = 4'd1;
							state_d = BK_FRAME;
						end
						JOB_VALUE: begin
							kind_d  = KIND_VALUE;
							value_d = head_job.value;
						end
						JOB_NACK: kind_d = KIND_NACK;
						default:  kind_d = KIND_TIMEOUT;
					endcase
				end
			end
			BK_FRAME: begin
				if (slot_free) begin
					out_valid_d = 1'b1;
					kind_d      = KIND_TX;
					char_d      = frame_char;
					value_d     = 16'd0;
					last_d      = (pos_q == last_pos);
					pos_d       = pos_q + 4'd1;
					if (pos_q == last_pos) begin
						state_d = BK_IDLE;
					end
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			pos_q       <= 4'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			pos_q       <= pos_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Output payload and frame bytes.
	always_ff @(posedge clk) begin
		kind_q  <= kind_d;
		char_q  <= char_d;
		value_q <= value_d;
		last_q  <= last_d;
		if (load) begin
			is_set_q   <= job_set;
			cmd_q      <= job_cmd;
			bytes_q[0] <= head_job.reg_id[7:0];
			bytes_q[1] <= head_job.reg_id[15:8];
			bytes_q[2] <= 8'd0;
			bytes_q[3] <= job_set ? head_job.value[7:0] : chk;
			bytes_q[4] <= job_set ? head_job.value[15:8] : 8'd0;
			bytes_q[5] <= job_set ? chk : 8'd0;
		end
	end

endmodule

>>> hdl/hex_register_link_endpoint_core.sv
// ASCII-hex register link endpoint. Requests arrive on in_ch: a received line
// character, a get or set request for the configured target register, or a
// timer tick. The front end takes one request per clock cycle, tracks the
// receive framing (colon to newline) and the reply wait, and hands any work
// to a four-entry job queue. The back end drains that queue: a get request
// becomes 11 transmit characters and a set request 15, delivered one per cycle
// while the receiver is ready, with last on the newline; a matching reply, a
// NACK or a timeout yields one result with last set. Results leave through an
// output register, so requests keep flowing while a result waits; the front
// end stalls only when the job queue is full, which the one-character-per-cycle
// frame serializer sets. The APB port holds target_register at address 0x0 and
// timeout_ticks at 0x4; write them only while the block is idle.
module hex_register_link_endpoint_core
	import hrle_pkg::*;
#(
	parameter int MAX_FRAME_CHARS = MAX_FRAME_CHARS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	hrle_in_if.sink     in_ch,
	hrle_out_if.source  out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [15:0] target_q;
	logic [15:0] timeout_q;
	logic        cfg_write;

	queue_stat_t qstat;
	logic        push;
	job_t        push_job;
	logic        pop;
	job_t        head_job;

	// Configuration registers.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign prdata    = (paddr[2] == REG_TIMEOUT) ? {16'd0, timeout_q} : {16'd0, target_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q  <= TARGET_RESET;
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_write) begin
			if (paddr[2] == REG_TARGET) begin
				target_q <= pwdata[15:0];
			end else begin
				timeout_q <= pwdata[15:0];
			end
		end
	end

	hrle_front #(
		.MAX_FRAME_CHARS(MAX_FRAME_CHARS)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_ch           (in_ch),
		.target_register (target_q),
		.timeout_ticks   (timeout_q),
		.qstat           (qstat),
		.push            (push),
		.push_job        (push_job)
	);

	hrle_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head_job (head_job),
		.stat     (qstat)
	);

	hrle_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.qstat    (qstat),
		.head_job (head_job),
		.pop      (pop),
		.out_ch   (out_ch)
	);

endmodule

>>> hdl/hrle_checker.sv
module hrle_checker
	import hrle_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  kind,
	input logic [7:0]  tx_char,
	input logic [15:0] reply_value,
	input logic        last
);

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn while stalled");

	// A stalled result keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(kind) && $stable(tx_char) &&
		$stable(reply_value) && $stable(last))
		else $error("result payload changed while stalled");

	// Reports are always single results.
	a_report_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_TX |-> last)
		else $error("report without last");

	// A colon opens a frame and never ends it.
	a_colon_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_TX && tx_char == CH_COLON |-> !last)
		else $error("frame ended on a colon");

	// Transmit characters are framing or uppercase hex only.
	a_tx_charset: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_TX |-> tx_char == CH_COLON || tx_char == CH_NL ||
		(tx_char >= 8'h30 && tx_char <= 8'h39) || (tx_char >= 8'h41 && tx_char <= 8'h46))
		else $error("illegal transmit character");

endmodule

bind hex_register_link_endpoint_core hrle_checker u_hrle_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.kind        (out_ch.kind),
	.tx_char     (out_ch.tx_char),
	.reply_value (out_ch.reply_value),
	.last        (out_ch.last)
);

>>> sim/tb_hex_register_link_endpoint_core.sv
module tb_hex_register_link_endpoint_core
	import hrle_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT   = 4000;
	localparam int SETTLE_CYCLES = 12;
	localparam int HOLD_CYCLES   = 300;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  tx_char;
		logic [15:0] reply_value;
		logic        last;
	} link_result_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	hrle_in_if  in_ch ();
	hrle_out_if out_ch ();

	hex_register_link_endpoint_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Results the endpoint still owes, oldest first.
	link_result_t owed_results[$];
	int mismatches = 0;
	int items_sent = 0;
	bit idle_on = 1'b1;
	int hold_cycles = 0;

	// Shadow of the configuration registers.
	logic [15:0] cfg_target  = TARGET_RESET;
	logic [15:0] cfg_timeout = TIMEOUT_RESET;

	// Shadow of the receive framer and the reply wait.
	bit          rx_in_frame    = 1'b0;
	int          rx_char_count  = 0;
	bit          rx_type_seen   = 1'b0;
	bit          rx_half_byte   = 1'b0;
	logic [3:0]  rx_high_nibble = 4'h0;
	int          rx_byte_count  = 0;
	logic [3:0]  rx_type        = 4'h0;
	logic [15:0] rx_register    = 16'h0000;
	logic [15:0] rx_value       = 16'h0000;
	bit          rx_voided      = 1'b0;
	bit          wait_active    = 1'b0;
	logic [15:0] wait_ticks     = 16'h0000;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic void owe(logic [1:0] kind, logic [7:0] ch, logic [15:0] value,
			logic last);
		link_result_t r;
		r.kind        = kind;
		r.tx_char     = ch;
		r.reply_value = value;
		r.last        = last;
		owed_results = {owed_results, r};
	endfunction

	// Value of a hex digit in either case, or -1 when the character is not one.
	function automatic int digit_value(logic [7:0] c);
		int d;
		d = -1;
		if (c >= 8'h30 && c <= 8'h39) begin
			d = int'(c) - 8'h30;
		end else if (c >= 8'h41 && c <= 8'h46) begin
			d = int'(c) - 8'h41 + 10;
		end else if (c >= 8'h61 && c <= 8'h66) begin
			d = int'(c) - 8'h61 + 10;
		end
		return d;
	endfunction

	function automatic logic [7:0] digit_char(logic [3:0] v, bit lower);
		logic [7:0] c;
		if (v < 4'd10) begin
			c = 8'h30 + 8'(v);
		end else begin
			c = (lower ? 8'h61 : 8'h41) + 8'(v) - 8'd10;
		end
		return c;
	endfunction

	// A get or set command frame, and the start of the wait for its reply.
	function automatic void owe_command(bit is_set, logic [15:0] value);
		logic [7:0] body[6];
		logic [7:0] sum;
		logic [3:0] cmd;
		int count;
		cmd = is_set ? CMD_SET : CMD_GET;
		body[0] = cfg_target[7:0];
		body[1] = cfg_target[15:8];
		body[2] = 8'h00;
		count = 3;
		if (is_set) begin
			body[3] = value[7:0];
			body[4] = value[15:8];
			count = 5;
		end
		sum = 8'(cmd);
		for (int i = 0; i < count; i++) begin
			sum = sum + body[i];
		end
		body[count] = CHECK_SUM - sum;
		count++;
		owe(KIND_TX, CH_COLON, 16'h0000, 1'b0);
		owe(KIND_TX, digit_char(cmd, 1'b0), 16'h0000, 1'b0);
		for (int i = 0; i < count; i++) begin
			owe(KIND_TX, digit_char(body[i][7:4], 1'b0), 16'h0000, 1'b0);
			owe(KIND_TX, digit_char(body[i][3:0], 1'b0), 16'h0000, 1'b0);
		end
		owe(KIND_TX, CH_NL, 16'h0000, 1'b1);
		wait_active = 1'b1;
		wait_ticks  = 16'h0000;
	endfunction

	// One received character through the framer and the reply decoder.
	function automatic void take_line_char(logic [7:0] c);
		int d;
		logic [7:0] b;
		if (c == CH_COLON) begin
			rx_in_frame    = 1'b1;
			rx_char_count  = 1;
			rx_type_seen   = 1'b0;
			rx_half_byte   = 1'b0;
			rx_high_nibble = 4'h0;
			rx_byte_count  = 0;
			rx_type        = 4'h0;
			rx_register    = 16'h0000;
			rx_value       = 16'h0000;
			rx_voided      = 1'b0;
		end else if (rx_in_frame) begin
			if (c == CH_NL) begin
				rx_in_frame   = 1'b0;
				rx_char_count = 0;
				if (!rx_voided && rx_type_seen && rx_byte_count >= 1) begin
					if (rx_type == CMD_GET || rx_type == CMD_SET) begin
						if (rx_byte_count >= 6 && rx_register == cfg_target) begin
							wait_active = 1'b0;
							owe(KIND_VALUE, 8'h00, rx_value, 1'b1);
						end
					end else if (rx_type == CMD_NACK) begin
						wait_active = 1'b0;
						owe(KIND_NACK, 8'h00, 16'h0000, 1'b1);
					end
				end
			end else if (rx_char_count >= MAX_FRAME_CHARS_DEF) begin
				// An overlong frame is dropped without a trace.
				rx_in_frame   = 1'b0;
				rx_char_count = 0;
			end else begin
				rx_char_count++;
				d = digit_value(c);
				if (d < 0) begin
					rx_voided = 1'b1;
				end else if (!rx_type_seen) begin
					rx_type      = d[3:0];
					rx_type_seen = 1'b1;
				end else if (!rx_half_byte) begin
					rx_high_nibble = d[3:0];
					rx_half_byte   = 1'b1;
				end else begin
					rx_half_byte = 1'b0;
					b = {rx_high_nibble, d[3:0]};
					case (rx_byte_count)
						0: rx_register[7:0]  = b;
						1: rx_register[15:8] = b;
						3: rx_value[7:0]     = b;
						4: rx_value[15:8]    = b;
						default: ;
					endcase
					if (rx_byte_count < 7) begin
						rx_byte_count++;
					end
				end
			end
		end
	endfunction

	function automatic void predict_request(logic [1:0] op, logic [7:0] ch,
			logic [15:0] value);
		case (op)
			OP_RX: take_line_char(ch);
			OP_GET: owe_command(1'b0, 16'h0000);
			OP_SET: owe_command(1'b1, value);
			default: begin
				if (wait_active) begin
					if (wait_ticks >= cfg_timeout) begin
						wait_active = 1'b0;
						owe(KIND_TIMEOUT, 8'h00, 16'h0000, 1'b1);
					end else begin
						wait_ticks = wait_ticks + 16'd1;
					end
				end
			end
		endcase
	endfunction

	// Offer one request after a random gap and hold it until it is taken.
	task automatic send_item(logic [1:0] op, logic [7:0] ch, logic [15:0] value);
		int gap;
		gap = idle_on ? int'($urandom_range(0, 15)) : 0;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.opcode    <= op;
		in_ch.rx_char   <= ch;
		in_ch.set_value <= value;
		do @(posedge clk); while (!in_ch.ready);
		items_sent++;
		predict_request(op, ch, value);
	endtask

	function automatic logic [7:0] bad_char();
		logic [7:0] c;
		do begin
			c = 8'($urandom);
		end while (digit_value(c) >= 0 || c == CH_COLON || c == CH_NL);
		return c;
	endfunction

	// Send a reply frame character by character. bad_at replaces the digit at
	// that position (0 is the type digit) with a non-hex character.
	task automatic send_frame(logic [3:0] type_digit, logic [15:0] reg_id,
			logic [15:0] value, int nbytes, bit lower, bit odd_tail, int bad_at,
			bit close);
		logic [7:0] line[$];
		logic [7:0] b;
		line = {line, CH_COLON};
		line = {line, digit_char(type_digit, lower)};
		for (int i = 0; i < nbytes; i++) begin
			case (i)
				0: b = reg_id[7:0];
				1: b = reg_id[15:8];
				2: b = 8'h00;
				3: b = value[7:0];
				4: b = value[15:8];
				default: b = 8'($urandom);
			endcase
			line = {line, digit_char(b[7:4], lower)};
			line = {line, digit_char(b[3:0], lower)};
		end
		if (odd_tail) begin
			line = {line, digit_char(4'($urandom), lower)};
		end
		if (bad_at >= 0 && bad_at + 1 < line.size()) begin
			line[bad_at + 1] = bad_char();
		end
		if (close) begin
			line = {line, CH_NL};
		end
		foreach (line[i]) begin
			send_item(OP_RX, line[i], 16'($urandom));
		end
	endtask

	// Stop offering requests until every owed result has come out.
	task automatic wait_quiet();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (owed_results.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [15:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {16'h0000, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (idx == REG_TARGET) begin
			cfg_target = value;
		end else begin
			cfg_timeout = value;
		end
		@(posedge clk);
	endtask

	// Command frames at the value extremes and with a mixed bit pattern.
	task automatic test_commands();
		send_item(OP_GET, 8'h00, 16'h0000);
		send_item(OP_SET, 8'hFF, 16'h0000);
		send_item(OP_SET, 8'h00, 16'hFFFF);
		send_item(OP_SET, 8'h5A, 16'h5AA5);
	endtask

	// Reply decoding: matches, NACKs, short, voided and foreign-type frames.
	task automatic test_replies();
		send_item(OP_RX, 8'h78, 16'h0000);
		send_item(OP_RX, CH_NL, 16'h0000);
		send_frame(CMD_GET, cfg_target, 16'hFFFF, 6, 1'b0, 1'b0, -1, 1'b1);
		send_frame(CMD_SET, cfg_target, 16'h0000, 6, 1'b1, 1'b1, -1, 1'b1);
		send_frame(CMD_NACK, 16'h0000, 16'h0000, 0, 1'b0, 1'b1, -1, 1'b1);
		send_frame(CMD_SET, cfg_target, 16'h4321, 5, 1'b0, 1'b0, -1, 1'b1);
		send_frame(CMD_GET, cfg_target, 16'h4321, 6, 1'b0, 1'b0, 4, 1'b1);
		send_frame(4'h3, cfg_target, 16'h4321, 1, 1'b0, 1'b0, -1, 1'b1);
		// An abandoned frame is replaced by the one whose colon follows it.
		send_frame(CMD_NACK, 16'h0000, 16'h0000, 1, 1'b0, 1'b0, -1, 1'b0);
		send_frame(CMD_NACK, 16'h0000, 16'h0000, 1, 1'b1, 1'b0, -1, 1'b1);
	endtask

	// Wait and timeout handling; meant for a timeout of one tick.
	task automatic test_timeout();
		send_item(OP_TICK, 8'h00, 16'h0000);
		send_item(OP_GET, 8'h00, 16'h0000);
		repeat (3) send_item(OP_TICK, 8'h00, 16'h0000);
		send_item(OP_SET, 8'h00, 16'h1234);
		send_frame(CMD_SET, cfg_target, 16'h1234, 6, 1'b0, 1'b0, -1, 1'b1);
		send_item(OP_TICK, 8'h00, 16'h0000);
		send_item(OP_GET, 8'h00, 16'h0000);
		send_frame(CMD_NACK, 16'h0000, 16'h0000, 1, 1'b0, 1'b0, -1, 1'b1);
		send_item(OP_TICK, 8'h00, 16'h0000);
		send_item(OP_GET, 8'h00, 16'h0000);
		send_frame(CMD_GET, cfg_target + 16'd1, 16'h0001, 6, 1'b0, 1'b0, -1, 1'b1);
		repeat (2) send_item(OP_TICK, 8'h00, 16'h0000);
	endtask

	// The receiver holds off while command requests keep coming, so the job
	// queue fills and the input stalls.
	task automatic test_backpressure();
		idle_on = 1'b0;
		hold_cycles = HOLD_CYCLES;
		for (int i = 0; i < 6; i++) begin
			send_item(i[0] ? OP_GET : OP_SET, 8'($urandom), 16'($urandom));
		end
		send_frame(CMD_NACK, 16'($urandom), 16'h0000, 1, 1'b0, 1'b0, -1, 1'b1);
		send_item(OP_TICK, 8'h00, 16'h0000);
		idle_on = 1'b1;
		wait_quiet();
	endtask

	// Mostly well-formed reply frames with random content, mixed with
	// commands, tick bursts, stray characters and broken frames.
	task automatic test_random_traffic(int budget);
		int start;
		int pick;
		logic [3:0] digit;
		logic [15:0] reg_id;
		int nbytes;
		start = items_sent;
		while (items_sent - start < budget) begin
			if ($urandom_range(0, 9) == 0) begin
				idle_on = !idle_on;
			end
			pick = int'($urandom_range(0, 99));
			if (pick < 45) begin
				pick = int'($urandom_range(0, 19));
				digit = (pick < 12) ? (pick[0] ? CMD_GET : CMD_SET) :
					(pick < 15) ? CMD_NACK : 4'($urandom);
				reg_id = ($urandom_range(0, 3) != 0) ? cfg_target : 16'($urandom);
				nbytes = ($urandom_range(0, 4) != 0) ? int'($urandom_range(6, 8)) :
					int'($urandom_range(0, 5));
				send_frame(digit, reg_id, 16'($urandom), nbytes,
					1'($urandom_range(0, 1)), $urandom_range(0, 5) == 0, -1, 1'b1);
			end else if (pick < 60) begin
				send_item($urandom_range(0, 1) ? OP_GET : OP_SET, 8'($urandom),
					16'($urandom));
			end else if (pick < 75) begin
				repeat ($urandom_range(1, 8)) send_item(OP_TICK, 8'($urandom),
					16'($urandom));
			end else if (pick < 85) begin
				send_item(OP_RX, 8'($urandom), 16'($urandom));
				// Stray characters do not count toward the budget.
				items_sent--;
			end else begin
				case ($urandom_range(0, 2))
					0: send_frame(CMD_GET, cfg_target, 16'($urandom), 6, 1'b0, 1'b0,
						int'($urandom_range(0, 12)), 1'b1);
					1: begin
						send_frame(CMD_NACK, 16'($urandom), 16'($urandom),
							int'($urandom_range(0, 6)), 1'b0, 1'b0, -1, 1'b0);
						send_frame(CMD_SET, cfg_target, 16'($urandom), 6, 1'b1, 1'b0,
							-1, 1'b1);
					end
					default: send_frame($urandom_range(0, 1) ? CMD_GET : CMD_NACK,
						cfg_target, 16'($urandom), int'($urandom_range(0, 5)), 1'b0,
						1'($urandom_range(0, 1)), -1, 1'b1);
				endcase
			end
		end
		idle_on = 1'b1;
	endtask

	// Result receiver: random stalls, plus one long hold-off on request.
	initial begin : result_sink
		int stall;
		out_ch.ready <= 1'b0;
		@(posedge clk iff arst_n);
		forever begin
			if (hold_cycles > 0) begin
				out_ch.ready <= 1'b0;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
			end
			stall = idle_on ? int'($urandom_range(0, 15)) : 0;
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
		end
	end

	function automatic void compare_field(string field, int want, int got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field,
				want, got);
		end
	endfunction

	// Compare each result taken from the endpoint with the oldest one owed.
	always @(posedge clk) begin : result_check
		link_result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (owed_results.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result, expected none, %s %0d %0h %0h %0d",
					$time, "actual kind/char/value/last", out_ch.kind, out_ch.tx_char,
					out_ch.reply_value, out_ch.last);
			end else begin
				want = owed_results.pop_front();
				compare_field("kind", int'(want.kind), int'(out_ch.kind));
				compare_field("tx_char", int'(want.tx_char), int'(out_ch.tx_char));
				compare_field("reply_value", int'(want.reply_value),
					int'(out_ch.reply_value));
				compare_field("last", int'(want.last), int'(out_ch.last));
			end
		end
	end

	// End the run when nothing moves on either channel for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("tb: failure");
		$finish;
	end

	initial begin
		arst_n          <= 1'b0;
		in_ch.valid     <= 1'b0;
		in_ch.opcode    <= OP_TICK;
		in_ch.rx_char   <= 8'h00;
		in_ch.set_value <= 16'h0000;
		psel            <= 1'b0;
		penable         <= 1'b0;
		pwrite          <= 1'b0;
		paddr           <= 3'd0;
		pwdata          <= 32'h0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset configuration.
		test_commands();
		test_replies();
		wait_quiet();

		// Lowest register id and a timeout of one tick.
		write_reg(REG_TARGET, 16'h0000);
		write_reg(REG_TIMEOUT, 16'd1);
		test_timeout();
		wait_quiet();

		// Highest register id and the longest timeout.
		write_reg(REG_TARGET, 16'hFFFF);
		write_reg(REG_TIMEOUT, 16'hFFFF);
		test_backpressure();

		// Random register id with short timeouts so the wait often expires.
		write_reg(REG_TARGET, 16'($urandom));
		write_reg(REG_TIMEOUT, 16'($urandom_range(1, 6)));
		test_random_traffic(16);
		wait_quiet();

		if (mismatches == 0 && owed_results.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
